// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/nic_pkg.sv =====
// ---------------------------------------------------------------------------
// Node id compaction package
// Widths, defaults and the item types shared by the compaction modules.
// ---------------------------------------------------------------------------
`default_nettype none

package nic_pkg;

  localparam int ID_W            = 16;
  localparam int START_W         = 8;
  localparam int NODE_COUNT_DEF  = 65536;
  localparam int CMD_DEPTH_DEF   = 2;
  localparam int RES_DEPTH_DEF   = 2;
  localparam int APB_AW          = 3;
  localparam int APB_DW          = 32;

  localparam logic [APB_AW-3:0] REG_START_VALUE = 1'b0;

  typedef struct packed {
    logic            is_trans;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic            last;
    logic            a_in;
    logic            b_in;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] new_a;
    logic [ID_W-1:0] new_b;
    logic            unknown_id;
  } res_t;

  typedef struct packed {
    logic [START_W-1:0] start_value;
    logic               cfg_wr;
  } ctrl_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/nic_fifo.sv =====
// ---------------------------------------------------------------------------
// Node id compaction queue
// Small register FIFO that decouples the front, the back and the result side.
// ---------------------------------------------------------------------------
`default_nettype none

module nic_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/nic_front.sv =====
// ---------------------------------------------------------------------------
// Node id compaction front end
// Accept edge items, range-check both ids and queue them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module nic_front #(
  parameter int NODE_COUNT = nic_pkg::NODE_COUNT_DEF
) (
  input  logic                      push_i,
  input  logic                      req_type_i,
  input  logic [nic_pkg::ID_W-1:0]  node_a_i,
  input  logic [nic_pkg::ID_W-1:0]  node_b_i,
  input  logic                      last_i,
  output logic                      full_o,
  input  nic_pkg::stat_t            stat_i,
  input  logic                      cmd_full_i,
  output logic                      cmd_push_o,
  output nic_pkg::cmd_t             cmd_o
);

  import nic_pkg::*;

  localparam int DEPTH = (NODE_COUNT > (2 ** ID_W)) ? (2 ** ID_W) : NODE_COUNT;

  assign full_o     = cmd_full_i || stat_i.clearing;
  assign cmd_push_o = push_i && !full_o;

  always_comb begin
    cmd_o.is_trans = req_type_i;
    cmd_o.a        = node_a_i;
    cmd_o.b        = node_b_i;
    cmd_o.last     = last_i;
    cmd_o.a_in     = ({1'b0, node_a_i} < (ID_W + 1)'(DEPTH));
    cmd_o.b_in     = ({1'b0, node_b_i} < (ID_W + 1)'(DEPTH));
  end

endmodule

`default_nettype wire

// ===== src/nic_back.sv =====
// ---------------------------------------------------------------------------
// Node id compaction back end
// Used bitmap, gap table walk and translation of queued items.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nic_back #(
  parameter int NODE_COUNT = nic_pkg::NODE_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nic_pkg::ctrl_t ctrl_i,
  input  logic           cmd_valid_i,
  input  nic_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output nic_pkg::res_t  res_o,
  output nic_pkg::stat_t stat_o
);

  import nic_pkg::*;

  localparam int DEPTH = (NODE_COUNT > (2 ** ID_W)) ? (2 ** ID_W) : NODE_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ID_W + 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MARK_B = 3'd2;
  localparam logic [2:0] S_TR_B   = 3'd3;
  localparam logic [2:0] S_TR_OUT = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;

  logic            used_mem [DEPTH];
  logic [ID_W-1:0] gap_mem  [DEPTH];

  logic [2:0]      state_q, state_d;
  logic [AW:0]     clr_addr_q, clr_addr_d;
  logic [AW-1:0]   largest_q, largest_d;
  logic            ready_q, ready_d;
  logic [AW:0]     walk_addr_q, walk_addr_d;
  logic            walk_vld_q, walk_vld_d;
  logic [AW-1:0]   walk_wr_q, walk_wr_d;
  logic [ID_W-1:0] cnt_q, cnt_d;
  logic [ID_W-1:0] cnt_new;
  logic [ID_W-1:0] new_a_q, new_a_d;
  logic            unk_a_q, unk_a_d;

  logic            u_we, u_wdata, u_re, u_rdata_q;
  logic [AW-1:0]   u_waddr, u_raddr;
  logic            g_we, g_re;
  logic [AW-1:0]   g_waddr, g_raddr;
  logic [ID_W-1:0] g_wdata, g_rdata_q;

  logic [XW-1:0]   largest_x, start_x, a_x, b_x;
  logic [ID_W-1:0] comp_id;

  function automatic logic [ID_W-1:0] compact(
    input logic [ID_W-1:0] id,
    input logic            in_rng,
    input logic [ID_W-1:0] gdata,
    input logic            rdy,
    input logic [XW-1:0]   start_v,
    input logic [XW-1:0]   lgst
  );
    logic [XW-1:0]   idx;
    logic [ID_W-1:0] gap;
    idx = {1'b0, id};
    gap = ((idx > lgst) && (start_v > lgst)) ? '0 : gdata;
    if (!rdy || !in_rng || (idx < start_v)) begin
      return id;
    end
    return (gap > id) ? '0 : (id - gap);
  endfunction

  assign largest_x = XW'(largest_q);
  assign start_x   = XW'(ctrl_i.start_value);
  assign a_x       = {1'b0, cmd_i.a};
  assign b_x       = {1'b0, cmd_i.b};
  assign cnt_new   = cnt_q + ID_W'(!u_rdata_q);
  assign stat_o.clearing = (state_q == S_CLEAR);

  always_comb begin
    comp_id = compact(cmd_i.b, cmd_i.b_in, g_rdata_q, ready_q, start_x, largest_x);
    res_o.new_a      = new_a_q;
    res_o.new_b      = comp_id;
    res_o.unknown_id = unk_a_q || !(cmd_i.b_in && u_rdata_q);
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    largest_d   = largest_q;
    ready_d     = ready_q;
    walk_addr_d = walk_addr_q;
    walk_vld_d  = 1'b0;
    walk_wr_d   = walk_wr_q;
    cnt_d       = cnt_q;
    new_a_d     = new_a_q;
    unk_a_d     = unk_a_q;
    u_we        = 1'b0;
    u_waddr     = cmd_i.a[AW-1:0];
    u_wdata     = 1'b1;
    u_re        = 1'b0;
    u_raddr     = cmd_i.a[AW-1:0];
    g_we        = 1'b0;
    g_waddr     = walk_wr_q;
    g_wdata     = cnt_new;
    g_re        = 1'b0;
    g_raddr     = (a_x <= largest_x) ? cmd_i.a[AW-1:0] : largest_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q < (AW + 1)'(DEPTH)) begin
          u_we       = 1'b1;
          u_waddr    = clr_addr_q[AW-1:0];
          u_wdata    = 1'b0;
          clr_addr_d = clr_addr_q + (AW + 1)'(1);
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (!cmd_i.is_trans) begin
            u_we    = cmd_i.a_in;
            ready_d = 1'b0;
            if (cmd_i.a_in && (a_x > largest_x)) begin
              largest_d = cmd_i.a[AW-1:0];
            end
            state_d = S_MARK_B;
          end else begin
            u_re    = 1'b1;
            g_re    = 1'b1;
            state_d = S_TR_B;
          end
        end
      end
      S_MARK_B: begin
        u_we      = cmd_i.b_in;
        u_waddr   = cmd_i.b[AW-1:0];
        cmd_pop_o = 1'b1;
        if (cmd_i.b_in && (b_x > largest_x)) begin
          largest_d = cmd_i.b[AW-1:0];
        end
        if (cmd_i.last) begin
          walk_addr_d = (AW + 1)'(ctrl_i.start_value);
          cnt_d       = '0;
          state_d     = S_WALK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TR_B: begin
        new_a_d = compact(cmd_i.a, cmd_i.a_in, g_rdata_q, ready_q, start_x, largest_x);
        unk_a_d = !(cmd_i.a_in && u_rdata_q);
        u_re    = 1'b1;
        u_raddr = cmd_i.b[AW-1:0];
        g_re    = 1'b1;
        g_raddr = (b_x <= largest_x) ? cmd_i.b[AW-1:0] : largest_q;
        state_d = S_TR_OUT;
      end
      S_TR_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          cmd_pop_o  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_WALK: begin
        if (XW'(walk_addr_q) <= largest_x) begin
          u_re        = 1'b1;
          u_raddr     = walk_addr_q[AW-1:0];
          walk_vld_d  = 1'b1;
          walk_wr_d   = walk_addr_q[AW-1:0];
          walk_addr_d = walk_addr_q + (AW + 1)'(1);
        end else if (!walk_vld_q) begin
          ready_d = 1'b1;
          state_d = S_IDLE;
        end
        if (walk_vld_q) begin
          g_we  = 1'b1;
          cnt_d = cnt_new;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ctrl_i.cfg_wr) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      largest_q  <= '0;
      ready_q    <= 1'b0;
      walk_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      largest_q  <= largest_d;
      ready_q    <= ready_d;
      walk_vld_q <= walk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_addr_q <= walk_addr_d;
    walk_wr_q   <= walk_wr_d;
    cnt_q       <= cnt_d;
    new_a_q     <= new_a_d;
    unk_a_q     <= unk_a_d;
  end

  always_ff @(posedge clk_i) begin
    if (u_we) begin
      used_mem[u_waddr] <= u_wdata;
    end
    if (u_re) begin
      u_rdata_q <= used_mem[u_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gap_mem[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      g_rdata_q <= gap_mem[g_raddr];
    end
  end

  `ASSERT_IMPLY(a_push_state, clk_i, rst_ni, res_push_o, state_q == S_TR_OUT, "result outside output state")
  `ASSERT_IMPLY(a_pop_valid, clk_i, rst_ni, cmd_pop_o, cmd_valid_i, "pop of empty command queue")
  `ASSERT_IMPLY(a_gap_range, clk_i, rst_ni, g_we, walk_wr_q <= largest_q, "gap write past largest id")
  `ASSERT_NEXT(a_clear_done, clk_i, rst_ni, (state_q == S_CLEAR) && (clr_addr_q == (AW + 1)'(DEPTH)), state_q == S_IDLE, "clear pass does not finish")

endmodule

`default_nettype wire

// ===== src/node_id_compaction.sv =====
// ---------------------------------------------------------------------------
// Node id compaction
// Dense renumbering of graph node ids with a used bitmap and a gap table.
// ---------------------------------------------------------------------------
// After reset the block clears all min(NODE_COUNT, 65536) used bitmap entries
// with full high. Items are then taken one at a time by the back end: a mark
// item writes ids a and b in turn (one bitmap write port); a translate item
// reads a and b in turn and waits while the result queue is full (one read port
// each on bitmap and gap table); the mark item flagged last adds a gap walk
// from start_value to largest_id, one id per cycle through the bitmap read and
// gap table write ports (none if start_value > largest_id). A two-entry queue
// sits between front and back ends, another holds results. start_value (byte
// address 0) must be written only while idle; the block does not enforce it.
`default_nettype none

module node_id_compaction #(
  parameter int NODE_COUNT = nic_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nic_pkg::APB_AW-1:0]  paddr,
  input  logic [nic_pkg::APB_DW-1:0]  pwdata,
  output logic [nic_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic                        req_type_i,
  input  logic [nic_pkg::ID_W-1:0]    node_a_i,
  input  logic [nic_pkg::ID_W-1:0]    node_b_i,
  input  logic                        last_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [nic_pkg::ID_W-1:0]    new_a_o,
  output logic [nic_pkg::ID_W-1:0]    new_b_o,
  output logic                        unknown_id_o
);

  import nic_pkg::*;

  logic [START_W-1:0] start_q;
  logic               reg_hit;
  ctrl_t              ctrl;
  stat_t              stat;
  cmd_t               cmd_in, cmd_head;
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t               res_in, res_head;
  logic               res_push, res_full;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_START_VALUE);
  assign prdata  = reg_hit ? APB_DW'(start_q) : '0;

  assign ctrl.cfg_wr      = psel && penable && pwrite && reg_hit;
  assign ctrl.start_value = start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (ctrl.cfg_wr) begin
      start_q <= pwdata[START_W-1:0];
    end
  end

  nic_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .push_i     (push),
    .req_type_i (req_type_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .last_i     (last_i),
    .full_o     (full),
    .stat_i     (stat),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  nic_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH_DEF)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  nic_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .stat_o      (stat)
  );

  nic_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH_DEF)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign new_a_o      = res_head.new_a;
  assign new_b_o      = res_head.new_b;
  assign unknown_id_o = res_head.unknown_id;

endmodule

`default_nettype wire
